FILE: rtl/core/project_point_onto_circle_core_assert.svh
// assertion macros shared by the core
`ifndef PROJECT_POINT_ONTO_CIRCLE_CORE_ASSERT_SVH
`define PROJECT_POINT_ONTO_CIRCLE_CORE_ASSERT_SVH

// same-cycle implication
`define PPC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppc assertion failed");

// next-cycle implication
`define PPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppc assertion failed");

`endif

FILE: rtl/core/ppc_pkg.sv
package ppc_pkg;

   // default coordinate word width
   localparam int COORD_BITS_DEF = 32;

endpackage

FILE: rtl/core/ppc_sqrt2.sv
module ppc_sqrt2 #(
   parameter int ROOT_BITS = 34,
   parameter int SIDE_BITS = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [2*ROOT_BITS-1:0] in_rad_a,
   input  logic [2*ROOT_BITS-1:0] in_rad_b,
   input  logic [SIDE_BITS-1:0]   in_side,
   output logic                   out_valid,
   output logic [ROOT_BITS-1:0]   out_root_a,
   output logic [ROOT_BITS-1:0]   out_root_b,
   output logic [SIDE_BITS-1:0]   out_side
);

   localparam int RB = ROOT_BITS;

   logic               valid_ff  [RB];
   logic [RB+1:0]      rem_a_ff  [RB];
   logic [RB+1:0]      rem_b_ff  [RB];
   logic [RB-1:0]      root_a_ff [RB];
   logic [RB-1:0]      root_b_ff [RB];
   logic [2*RB-1:0]    rad_a_ff  [RB];
   logic [2*RB-1:0]    rad_b_ff  [RB];
   logic [SIDE_BITS-1:0] side_ff [RB];

   // one result bit: {remainder, root}
   function automatic logic [2*RB+1:0] sqrt_step(input logic [RB+1:0] rem,
                                                 input logic [RB-1:0] root,
                                                 input logic [1:0]    bits);
      logic [RB+1:0] cur;
      logic [RB+1:0] trial;
      cur   = {rem[RB-1:0], bits};
      trial = {root, 2'b01};
      if (cur >= trial) begin
         sqrt_step = {cur - trial, root[RB-2:0], 1'b1};
      end else begin
         sqrt_step = {cur, root[RB-2:0], 1'b0};
      end
   endfunction

   for (genvar i = 0; i < RB; i++) begin : g_stage
      logic              v_p;
      logic [RB+1:0]     ra_p, rb_p;
      logic [RB-1:0]     oa_p, ob_p;
      logic [2*RB-1:0]   na_p, nb_p;
      logic [SIDE_BITS-1:0] s_p;
      logic [2*RB+1:0]   step_a_in, step_b_in;

      if (i == 0) begin : g_head
         assign v_p  = in_valid;
         assign ra_p = '0;
         assign rb_p = '0;
         assign oa_p = '0;
         assign ob_p = '0;
         assign na_p = in_rad_a;
         assign nb_p = in_rad_b;
         assign s_p  = in_side;
      end else begin : g_body
         assign v_p  = valid_ff[i-1];
         assign ra_p = rem_a_ff[i-1];
         assign rb_p = rem_b_ff[i-1];
         assign oa_p = root_a_ff[i-1];
         assign ob_p = root_b_ff[i-1];
         assign na_p = rad_a_ff[i-1];
         assign nb_p = rad_b_ff[i-1];
         assign s_p  = side_ff[i-1];
      end

      assign step_a_in = sqrt_step(ra_p, oa_p, na_p[2*RB-1 -: 2]);
      assign step_b_in = sqrt_step(rb_p, ob_p, nb_p[2*RB-1 -: 2]);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= v_p;
         end
         rem_a_ff[i]  <= step_a_in[2*RB+1 -: RB+2];
         rem_b_ff[i]  <= step_b_in[2*RB+1 -: RB+2];
         root_a_ff[i] <= step_a_in[RB-1:0];
         root_b_ff[i] <= step_b_in[RB-1:0];
         rad_a_ff[i]  <= {na_p[2*RB-3:0], 2'b00};
         rad_b_ff[i]  <= {nb_p[2*RB-3:0], 2'b00};
         side_ff[i]   <= s_p;
      end
   end

   assign out_valid  = valid_ff[RB-1];
   assign out_root_a = root_a_ff[RB-1];
   assign out_root_b = root_b_ff[RB-1];
   assign out_side   = side_ff[RB-1];

endmodule

FILE: rtl/core/ppc_div2.sv
module ppc_div2 #(
   parameter int QUO_BITS  = 34,
   parameter int HEAD_BITS = 33,
   parameter int SIDE_BITS = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [HEAD_BITS+QUO_BITS-1:0] in_num_a,
   input  logic [HEAD_BITS+QUO_BITS-1:0] in_num_b,
   input  logic [QUO_BITS-1:0]           in_den,
   input  logic [SIDE_BITS-1:0]          in_side,
   output logic                          out_valid,
   output logic [QUO_BITS-1:0]           out_quo_a,
   output logic [QUO_BITS-1:0]           out_quo_b,
   output logic [SIDE_BITS-1:0]          out_side
);

   localparam int QB = QUO_BITS;
   localparam int NB = HEAD_BITS + QUO_BITS;

   logic               valid_ff [QB];
   logic [QB-1:0]      rem_a_ff [QB];
   logic [QB-1:0]      rem_b_ff [QB];
   logic [QB-1:0]      nq_a_ff  [QB];
   logic [QB-1:0]      nq_b_ff  [QB];
   logic [QB-1:0]      den_ff   [QB];
   logic [SIDE_BITS-1:0] side_ff [QB];

   logic               out_valid_ff;
   logic [QB-1:0]      quo_a_ff, quo_b_ff;
   logic [SIDE_BITS-1:0] out_side_ff;

   // one quotient bit: {remainder, shifted numerator with quotient bit}
   function automatic logic [2*QB-1:0] div_step(input logic [QB-1:0] rem,
                                                input logic [QB-1:0] nq,
                                                input logic [QB-1:0] den);
      logic [QB:0] cur;
      cur = {rem, nq[QB-1]};
      if (cur >= {1'b0, den}) begin
         div_step = {QB'(cur - {1'b0, den}), nq[QB-2:0], 1'b1};
      end else begin
         div_step = {cur[QB-1:0], nq[QB-2:0], 1'b0};
      end
   endfunction

   // round to nearest, ties away from zero
   function automatic logic [QB-1:0] round_q(input logic [QB-1:0] q,
                                             input logic [QB-1:0] rem,
                                             input logic [QB-1:0] den);
      round_q = (rem >= den - rem) ? q + QB'(1) : q;
   endfunction

   for (genvar i = 0; i < QB; i++) begin : g_stage
      logic              v_p;
      logic [QB-1:0]     ra_p, rb_p, qa_p, qb_p, d_p;
      logic [SIDE_BITS-1:0] s_p;
      logic [2*QB-1:0]   step_a_in, step_b_in;

      if (i == 0) begin : g_head
         assign v_p  = in_valid;
         assign ra_p = QB'(in_num_a[NB-1 -: HEAD_BITS]);
         assign rb_p = QB'(in_num_b[NB-1 -: HEAD_BITS]);
         assign qa_p = in_num_a[QB-1:0];
         assign qb_p = in_num_b[QB-1:0];
         assign d_p  = in_den;
         assign s_p  = in_side;
      end else begin : g_body
         assign v_p  = valid_ff[i-1];
         assign ra_p = rem_a_ff[i-1];
         assign rb_p = rem_b_ff[i-1];
         assign qa_p = nq_a_ff[i-1];
         assign qb_p = nq_b_ff[i-1];
         assign d_p  = den_ff[i-1];
         assign s_p  = side_ff[i-1];
      end

      assign step_a_in = div_step(ra_p, qa_p, d_p);
      assign step_b_in = div_step(rb_p, qb_p, d_p);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= v_p;
         end
         rem_a_ff[i] <= step_a_in[2*QB-1 -: QB];
         rem_b_ff[i] <= step_b_in[2*QB-1 -: QB];
         nq_a_ff[i]  <= step_a_in[QB-1:0];
         nq_b_ff[i]  <= step_b_in[QB-1:0];
         den_ff[i]   <= d_p;
         side_ff[i]  <= s_p;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[QB-1];
      end
      quo_a_ff    <= round_q(nq_a_ff[QB-1], rem_a_ff[QB-1], den_ff[QB-1]);
      quo_b_ff    <= round_q(nq_b_ff[QB-1], rem_b_ff[QB-1], den_ff[QB-1]);
      out_side_ff <= side_ff[QB-1];
   end

   assign out_valid = out_valid_ff;
   assign out_quo_a = quo_a_ff;
   assign out_quo_b = quo_b_ff;
   assign out_side  = out_side_ff;

endmodule

FILE: rtl/core/project_point_onto_circle_core.sv
// projection of a point onto a circle, signed fixed point
//
// request channel: drive start high with the centre, start and end point on
// the req_ ports; the transfer happens on any rising edge with start high and
// busy low. busy is always low, so a new request can be taken every cycle.
// response channel: rsp_strobe is high for exactly one cycle with the
// projected point and the degenerate and overflow flags on the rsp_ ports.
// the receiver cannot stall, and the core never needs it to.
// throughput one transfer per cycle. the pipeline is dominated by the two
// bit-per-stage units: COORD_BITS+2 stages of square root and COORD_BITS+3
// of division with rounding.
// reset clears the valid bits of every stage, so requests in flight are
// dropped and no response appears until new requests arrive.
// an end point equal to the centre returns the end point with degenerate set.
module project_point_onto_circle_core #(
   parameter int COORD_BITS = ppc_pkg::COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_BITS-1:0] req_center_x,
   input  logic [COORD_BITS-1:0] req_center_y,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   output logic                  rsp_strobe,
   output logic [COORD_BITS-1:0] rsp_proj_x,
   output logic [COORD_BITS-1:0] rsp_proj_y,
   output logic                  rsp_degenerate,
   output logic                  rsp_overflow
);

   localparam int W   = COORD_BITS;
   localparam int DW  = W + 1;            // magnitude of a difference
   localparam int SQ  = 2 * DW + 1;       // sum of two squares
   localparam int RW  = (SQ + 1) / 2;     // root and quotient width
   localparam int NW  = DW + RW;          // product |d| * radius
   localparam int PW  = W + RW;           // unsaturated result
   localparam int SB1 = 2 * W + 3 + 2 * DW;
   localparam int SB2 = 2 * W + 3;

   localparam logic [PW-1:0] P_MAX = {{(RW + 1){1'b0}}, {(W - 1){1'b1}}};
   localparam logic [PW-1:0] P_MIN = {{(RW + 1){1'b1}}, {(W - 1){1'b0}}};
   localparam logic [W-1:0]  O_MAX = {1'b0, {(W - 1){1'b1}}};
   localparam logic [W-1:0]  O_MIN = {1'b1, {(W - 1){1'b0}}};

   // the pipeline never stalls
   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // stage 1: differences and their magnitudes
   logic signed [DW-1:0] rx_in, ry_in, dx_in, dy_in;
   assign rx_in = $signed({req_start_x[W-1], req_start_x})
                - $signed({req_center_x[W-1], req_center_x});
   assign ry_in = $signed({req_start_y[W-1], req_start_y})
                - $signed({req_center_y[W-1], req_center_y});
   assign dx_in = $signed({req_center_x[W-1], req_center_x})
                - $signed({req_end_x[W-1], req_end_x});
   assign dy_in = $signed({req_center_y[W-1], req_center_y})
                - $signed({req_end_y[W-1], req_end_y});

   logic          s1_valid_ff;
   logic [DW-1:0] s1_rxm_ff, s1_rym_ff, s1_dxm_ff, s1_dym_ff;
   logic          s1_sgx_ff, s1_sgy_ff, s1_degen_ff;
   logic [W-1:0]  s1_cx_ff, s1_cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_rxm_ff   <= rx_in[DW-1] ? DW'(-rx_in) : DW'(rx_in);
      s1_rym_ff   <= ry_in[DW-1] ? DW'(-ry_in) : DW'(ry_in);
      s1_dxm_ff   <= dx_in[DW-1] ? DW'(-dx_in) : DW'(dx_in);
      s1_dym_ff   <= dy_in[DW-1] ? DW'(-dy_in) : DW'(dy_in);
      s1_sgx_ff   <= dx_in[DW-1];
      s1_sgy_ff   <= dy_in[DW-1];
      s1_degen_ff <= (dx_in == '0) && (dy_in == '0);
      s1_cx_ff    <= req_center_x;
      s1_cy_ff    <= req_center_y;
   end

   // stage 2: four squares
   logic            s2_valid_ff;
   logic [2*DW-1:0] s2_rx2_ff, s2_ry2_ff, s2_dx2_ff, s2_dy2_ff;
   logic [DW-1:0]   s2_dxm_ff, s2_dym_ff;
   logic            s2_sgx_ff, s2_sgy_ff, s2_degen_ff;
   logic [W-1:0]    s2_cx_ff, s2_cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_rx2_ff   <= s1_rxm_ff * s1_rxm_ff;
      s2_ry2_ff   <= s1_rym_ff * s1_rym_ff;
      s2_dx2_ff   <= s1_dxm_ff * s1_dxm_ff;
      s2_dy2_ff   <= s1_dym_ff * s1_dym_ff;
      s2_dxm_ff   <= s1_dxm_ff;
      s2_dym_ff   <= s1_dym_ff;
      s2_sgx_ff   <= s1_sgx_ff;
      s2_sgy_ff   <= s1_sgy_ff;
      s2_degen_ff <= s1_degen_ff;
      s2_cx_ff    <= s1_cx_ff;
      s2_cy_ff    <= s1_cy_ff;
   end

   // stage 3: squared radius and squared length
   logic           s3_valid_ff;
   logic [SQ-1:0]  s3_rad2_ff, s3_len2_ff;
   logic [SB1-1:0] s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_rad2_ff <= {1'b0, s2_rx2_ff} + {1'b0, s2_ry2_ff};
      s3_len2_ff <= {1'b0, s2_dx2_ff} + {1'b0, s2_dy2_ff};
      s3_side_ff <= {s2_cx_ff, s2_cy_ff, s2_sgx_ff, s2_sgy_ff, s2_degen_ff,
                     s2_dxm_ff, s2_dym_ff};
   end

   // square roots: radius on lane a, length on lane b
   logic           sq_valid;
   logic [RW-1:0]  sq_radius, sq_length;
   logic [SB1-1:0] sq_side;

   ppc_sqrt2 #(
      .ROOT_BITS (RW),
      .SIDE_BITS (SB1)
   ) u_sqrt (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s3_valid_ff),
      .in_rad_a   ((2 * RW)'(s3_rad2_ff)),
      .in_rad_b   ((2 * RW)'(s3_len2_ff)),
      .in_side    (s3_side_ff),
      .out_valid  (sq_valid),
      .out_root_a (sq_radius),
      .out_root_b (sq_length),
      .out_side   (sq_side)
   );

   // scale each axis magnitude by the radius
   logic [DW-1:0]  sq_dxm, sq_dym;
   assign sq_dxm = sq_side[2*DW-1 -: DW];
   assign sq_dym = sq_side[DW-1:0];

   logic           m_valid_ff;
   logic [NW-1:0]  m_px_ff, m_py_ff;
   logic [RW-1:0]  m_len_ff;
   logic [SB2-1:0] m_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= sq_valid;
      end
      m_px_ff   <= sq_dxm * sq_radius;
      m_py_ff   <= sq_dym * sq_radius;
      m_len_ff  <= sq_length;
      m_side_ff <= sq_side[SB1-1 -: SB2];
   end

   // rounded quotients |d| * radius / length
   logic           dv_valid;
   logic [RW-1:0]  dv_qx, dv_qy;
   logic [SB2-1:0] dv_side;

   ppc_div2 #(
      .QUO_BITS  (RW),
      .HEAD_BITS (DW),
      .SIDE_BITS (SB2)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_valid_ff),
      .in_num_a  (m_px_ff),
      .in_num_b  (m_py_ff),
      .in_den    (m_len_ff),
      .in_side   (m_side_ff),
      .out_valid (dv_valid),
      .out_quo_a (dv_qx),
      .out_quo_b (dv_qy),
      .out_side  (dv_side)
   );

   // final stage: step back from the centre and saturate
   logic [W-1:0] f_cx, f_cy;
   logic         f_sgx, f_sgy, f_degen;
   assign f_cx    = dv_side[SB2-1 -: W];
   assign f_cy    = dv_side[SB2-W-1 -: W];
   assign f_sgx   = dv_side[2];
   assign f_sgy   = dv_side[1];
   assign f_degen = dv_side[0];

   function automatic logic [W:0] clamp(input logic [PW-1:0] v);
      if (!v[PW-1] && (v > P_MAX)) begin
         clamp = {1'b1, O_MAX};
      end else if (v[PW-1] && (v < P_MIN)) begin
         clamp = {1'b1, O_MIN};
      end else begin
         clamp = {1'b0, v[W-1:0]};
      end
   endfunction

   logic [PW-1:0] cxe, cye, qxe, qye, px_in, py_in;
   logic [W:0]    satx_in, saty_in;
   assign cxe = {{RW{f_cx[W-1]}}, f_cx};
   assign cye = {{RW{f_cy[W-1]}}, f_cy};
   assign qxe = {{W{1'b0}}, dv_qx};
   assign qye = {{W{1'b0}}, dv_qy};
   assign px_in = f_sgx ? cxe + qxe : cxe - qxe;
   assign py_in = f_sgy ? cye + qye : cye - qye;
   assign satx_in = clamp(px_in);
   assign saty_in = clamp(py_in);

   logic         out_strobe_ff;
   logic [W-1:0] out_x_ff, out_y_ff;
   logic         out_degen_ff, out_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_strobe_ff <= 1'b0;
      end else begin
         out_strobe_ff <= dv_valid;
      end
      // a degenerate end point equals the centre, so the centre is returned
      if (f_degen) begin
         out_x_ff   <= f_cx;
         out_y_ff   <= f_cy;
         out_ovf_ff <= 1'b0;
      end else begin
         out_x_ff   <= satx_in[W-1:0];
         out_y_ff   <= saty_in[W-1:0];
         out_ovf_ff <= satx_in[W] || saty_in[W];
      end
      out_degen_ff <= f_degen;
   end

   assign rsp_strobe     = out_strobe_ff;
   assign rsp_proj_x     = out_x_ff;
   assign rsp_proj_y     = out_y_ff;
   assign rsp_degenerate = out_degen_ff;
   assign rsp_overflow   = out_ovf_ff;

   // some coordinate of the response sits on a range limit
   logic at_limit;
   assign at_limit = (rsp_proj_x == O_MAX) || (rsp_proj_x == O_MIN)
                  || (rsp_proj_y == O_MAX) || (rsp_proj_y == O_MIN);

`include "project_point_onto_circle_core_assert.svh"

   // every request enters the pipeline
   `PPC_ASSERT_NEXT(a_take, clock, reset, accept, s1_valid_ff)
   // a degenerate response never reports saturation
   `PPC_ASSERT_IMPLY(a_degen, clock, reset, rsp_strobe && rsp_degenerate, !rsp_overflow)
   // saturation leaves at least one coordinate at a range limit
   `PPC_ASSERT_IMPLY(a_sat, clock, reset, rsp_strobe && rsp_overflow, at_limit)

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

// scoreboard: predicts each projection and checks the responses in order
class projection_scoreboard;
   typedef struct {
      logic [31:0] px;
      logic [31:0] py;
      logic        degen;
      logic        ovf;
   } proj_type;

   proj_type pending_q[$];
   int    mismatches;

   function automatic logic [63:0] isqrt(logic [127:0] n);
      logic [63:0]  res;
      logic [63:0]  cand;
      logic [127:0] sq;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = res | (64'd1 << b);
         sq   = {64'd0, cand} * {64'd0, cand};
         if (sq <= n) res = cand;
      end
      return res;
   endfunction

   function automatic logic [31:0] axis(longint c, longint d, logic [63:0] radius,
                                        logic [63:0] len, ref logic ovf);
      logic [127:0] num;
      logic [127:0] q;
      logic [127:0] r;
      logic [63:0]  m;
      longint       p;
      m   = (d < 0) ? -d : d;
      num = {64'd0, m} * {64'd0, radius};
      q   = num / len;
      r   = num % len;
      if (r >= len - r) q++;
      if (q > (128'd1 << 52)) q = 128'd1 << 52;
      p = (d < 0) ? c + longint'(q[63:0]) : c - longint'(q[63:0]);
      if (p > 64'sd2147483647) begin
         p = 64'sd2147483647; ovf = 1;
      end
      if (p < -64'sd2147483648) begin
         p = -64'sd2147483648; ovf = 1;
      end
      return p[31:0];
   endfunction

   function void note_request(logic [31:0] cx, cy, sx, sy, ex, ey);
      longint       dx, dy, rx, ry;
      logic [63:0]  radius, len, mdx, mdy, mrx, mry;
      proj_type     e;
      logic         ovf;
      dx = longint'($signed(cx)) - longint'($signed(ex));
      dy = longint'($signed(cy)) - longint'($signed(ey));
      rx = longint'($signed(sx)) - longint'($signed(cx));
      ry = longint'($signed(sy)) - longint'($signed(cy));
      ovf = 0;
      if (dx == 0 && dy == 0) begin
         e = '{ex, ey, 1'b1, 1'b0};
      end else begin
         mdx = (dx < 0) ? -dx : dx;  mdy = (dy < 0) ? -dy : dy;
         mrx = (rx < 0) ? -rx : rx;  mry = (ry < 0) ? -ry : ry;
         radius = isqrt({64'd0, mrx} * {64'd0, mrx} + {64'd0, mry} * {64'd0, mry});
         len    = isqrt({64'd0, mdx} * {64'd0, mdx} + {64'd0, mdy} * {64'd0, mdy});
         e.px = axis($signed(cx), dx, radius, len, ovf);
         e.py = axis($signed(cy), dy, radius, len, ovf);
         e.degen = 0;
         e.ovf   = ovf;
      end
      pending_q.push_back(e);
   endfunction

   task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   task check_response(logic [31:0] px, py, logic degen, ovf);
      proj_type e;
      if (pending_q.size() == 0) begin
         report("response with nothing pending");
         return;
      end
      e = pending_q.pop_front();
      if (px !== e.px) report($sformatf("proj_x %h expected %h", px, e.px));
      if (py !== e.py) report($sformatf("proj_y %h expected %h", py, e.py));
      if (degen !== e.degen) report($sformatf("degenerate %b expected %b", degen, e.degen));
      if (ovf !== e.ovf) report($sformatf("overflow %b expected %b", ovf, e.ovf));
   endtask
endclass

module tb;
   localparam int LATENCY  = 74;
   localparam int WD_LIMIT = 4000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_center_x, req_center_y, req_start_x, req_start_y;
   logic [31:0] req_end_x, req_end_y;
   logic        rsp_strobe;
   logic [31:0] rsp_proj_x, rsp_proj_y;
   logic        rsp_degenerate, rsp_overflow;

   projection_scoreboard sb;
   int idle_pct;
   int quiet_cycles;

   project_point_onto_circle_core i_dut (
      .clock, .reset, .start, .busy,
      .req_center_x, .req_center_y, .req_start_x, .req_start_y,
      .req_end_x, .req_end_y,
      .rsp_strobe, .rsp_proj_x, .rsp_proj_y, .rsp_degenerate, .rsp_overflow
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // sample both channels at the rising edge; transfers are noted here
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (start && !busy)
            sb.note_request(req_center_x, req_center_y, req_start_x, req_start_y,
                            req_end_x, req_end_y);
         if (rsp_strobe)
            sb.check_response(rsp_proj_x, rsp_proj_y, rsp_degenerate, rsp_overflow);
         if ((start && !busy) || rsp_strobe) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   // watchdog: too long with no transfer in either direction
   always @(posedge clock) begin
      if (!reset && quiet_cycles >= WD_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // drive one request at the falling edge and hold it until transferred
   task send(logic [31:0] cx, cy, sx, sy, ex, ey);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 0;
      end
      @(negedge clock);
      start <= 1;
      req_center_x <= cx; req_center_y <= cy;
      req_start_x  <= sx; req_start_y  <= sy;
      req_end_x    <= ex; req_end_y    <= ey;
      do @(posedge clock); while (busy);
   endtask

   // a coordinate biased towards small offsets and the range extremes
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return 32'h8000_0000 + $urandom_range(3);
         1: return 32'h7fff_ffff - $urandom_range(3);
         2: return $urandom_range(2000) - 1000;
         default: return $urandom;
      endcase
   endfunction

   task send_random();
      logic [31:0] cx, cy, sx, sy, ex, ey;
      cx = rand_coord(); cy = rand_coord();
      sx = rand_coord(); sy = rand_coord();
      ex = rand_coord(); ey = rand_coord();
      case ($urandom_range(9))
         // end on the centre
         0: begin ex = cx; ey = cy; end
         // zero radius
         1: begin sx = cx; sy = cy; end
         // points near the centre, well-scaled geometry
         2, 3, 4: begin
            sx = cx + $urandom_range(1 << 20) - (1 << 19);
            sy = cy + $urandom_range(1 << 20) - (1 << 19);
            ex = cx + $urandom_range(1 << 20) - (1 << 19);
            ey = cy + $urandom_range(1 << 20) - (1 << 19);
         end
         default: ;
      endcase
      send(cx, cy, sx, sy, ex, ey);
   endtask

   initial begin
      sb = new();
      reset = 1;
      start = 0;
      idle_pct = 0;
      {req_center_x, req_center_y, req_start_x, req_start_y} = '0;
      {req_end_x, req_end_y} = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: degenerate, zero radius, axes, extremes, saturation
      send(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      send(32'h7fff_ffff, 32'h8000_0000, 32'd5, 32'd5, 32'h7fff_ffff, 32'h8000_0000);
      send(32'd100, 32'd100, 32'd100, 32'd100, 32'd500, 32'd7);
      send(32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'h0000_0300, 32'd0);
      send(32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'hffff_fd00);
      send(32'd0, 32'd0, 32'd3, 32'd4, 32'd6, 32'd8);
      send(32'd0, 32'd0, 32'd1, 32'd0, 32'd1, 32'd1);
      send(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
           32'h8000_0001, 32'h8000_0000);
      send(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
           32'h7fff_fffe, 32'h7fff_ffff);
      send(32'h7fff_0000, 32'd0, 32'h8000_0000, 32'd0, 32'h7fff_0001, 32'd0);
      send(32'h8001_0000, 32'd0, 32'h7fff_ffff, 32'd0, 32'h8000_ffff, 32'd0);
      send(32'd0, 32'd0, 32'hffff_ffff, 32'hffff_ffff, 32'h1234_5678, 32'h8765_4321);
      send(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
           32'h7fff_ffff, 32'h8000_0000);
      send(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
           32'h0000_ffff, 32'hffff_0000);
      send(32'd10, 32'd10, 32'd13, 32'd10, 32'd11, 32'd11);

      // random, in three idling phases
      idle_pct = 26;
      repeat (215) send_random();
      idle_pct = 73;
      repeat (215) send_random();
      idle_pct = 0;
      repeat (215) send_random();
      @(negedge clock);
      start <= 0;

      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (sb.mismatches == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
